@@ hw/rtl/bounded_value_list_engine_defines.svh @@
// Assertion macros for the bounded value list engine.
`ifndef BOUNDED_VALUE_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_VALUE_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BVLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BVLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bvle_pkg.sv @@
// Shared types and constants of the bounded value list engine.
package bvle_pkg;

  localparam int unsigned DefDepth     = 32;
  localparam int unsigned DefValueBits = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_SORT   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_KEEP_ORDER = 2'd0,
    CFG_ASCENDING  = 2'd1,
    CFG_CAPACITY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SWAP_RD,
    S_SWAP_WR,
    S_SORT_LD,
    S_SORT_X,
    S_SORT_RD,
    S_SORT_CMP,
    S_READ_RD,
    S_READ_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic eq;
    logic after;
  } cmp_res_t;

endpackage

@@ hw/rtl/bvle_store.sv @@
// Entry store: one write port, one registered read port, per-entry valid bits.
module bvle_store #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

@@ hw/rtl/bvle_cmp.sv @@
// Shared compare unit: equality and sort-order test of two signed values.
module bvle_cmp #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  input  logic                  ascending_i,
  output bvle_pkg::cmp_res_t    res_o
);
  import bvle_pkg::*;

  always_comb begin
    res_o.eq    = (a_i == b_i);
    res_o.after = ascending_i ? ($signed(a_i) > $signed(b_i))
                              : ($signed(a_i) < $signed(b_i));
  end

endmodule

@@ hw/rtl/bounded_value_list_engine.sv @@
// Top level of the bounded value list engine: sequencer, registers and handshakes.
//
//   channel | signals                              | direction
//   in      | in_valid_i/in_ready_o, operation/value/position | request in
//   out     | out_valid_o/out_ready_i, status/found_at/read_value/fill_count | result out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | register write
//
// One request at a time; every store read goes through a single registered read
// port, so each step of a walk has a read state and a compare or write state.
// Reset clears count and valid bits at once.
// The result holds in its register until taken; no new request is accepted meanwhile.
module bounded_value_list_engine #(
  parameter int unsigned DEPTH      = bvle_pkg::DefDepth,
  parameter int unsigned VALUE_BITS = bvle_pkg::DefValueBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [5:0]         found_at_o,
  output logic signed [31:0] read_value_o,
  output logic [5:0]         fill_count_o
);
  import bvle_pkg::*;
  `include "bounded_value_list_engine_defines.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 5) ? CW : 5;

  state_e state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [4:0]            pos_q, pos_d;
  logic [CW-1:0]         held_q, held_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         jdx_q, jdx_d;
  logic [VALUE_BITS-1:0] x_q, x_d;
  logic [1:0]            status_q, status_d;
  logic [5:0]            found_q, found_d;
  logic [31:0]           rd_q, rd_d;
  logic                  keep_q, asc_q;
  logic [5:0]            cap_q;
  logic [CW-1:0]         cap_eff;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata, cmp_b;
  cmp_res_t              cmp_res;

  bvle_store #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmp_b = (state_q == S_SORT_CMP) ? x_q : val_q;

  bvle_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
    .a_i         (rdata),
    .b_i         (cmp_b),
    .ascending_i (asc_q),
    .res_o       (cmp_res)
  );

  assign cap_eff = (int'(cap_q) > int'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
      asc_q  <= 1'b1;
      cap_q  <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEEP_ORDER: keep_q <= cfg_data_i[0];
        CFG_ASCENDING:  asc_q  <= cfg_data_i[0];
        CFG_CAPACITY:   cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    jdx_q    <= jdx_d;
    x_q      <= x_d;
    status_q <= status_d;
    found_q  <= found_d;
    rd_q     <= rd_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    pos_d    = pos_q;
    held_d   = held_q;
    idx_d    = idx_q;
    jdx_d    = jdx_q;
    x_d      = x_q;
    status_d = status_q;
    found_d  = found_q;
    rd_d     = rd_q;
    we       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = rdata;
    raddr    = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          val_d    = VALUE_BITS'(value_i);
          pos_d    = position_i;
          status_d = ST_OK;
          found_d  = '0;
          rd_d     = '0;
          idx_d    = '0;
          case (operation_i)
            OP_INSERT: state_d = S_INS;
            OP_REMOVE: state_d = S_SRCH_RD;
            OP_SEARCH: state_d = S_SRCH_RD;
            OP_SORT: begin
              idx_d   = CW'(1);
              state_d = S_SORT_LD;
            end
            OP_READ:   state_d = S_READ_RD;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_INS: begin
        if (held_q >= cap_eff) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = held_q[AW-1:0];
          wdata  = val_q;
          held_d = held_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_SRCH_RD: begin
        if (idx_q >= held_q) begin
          status_d = ST_NOT_FOUND;
          if (op_q == OP_SEARCH) begin
            found_d = 6'(cap_eff);
          end
          state_d = S_OUT;
        end else begin
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_res.eq) begin
          if (op_q == OP_SEARCH) begin
            found_d = 6'(idx_q);
            state_d = S_OUT;
          end else if (keep_q) begin
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_SWAP_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        raddr = AW'(idx_q + 1'b1);
        if (idx_q + 1'b1 >= held_q) begin
          held_d  = held_q - 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_SWAP_RD: begin
        raddr   = AW'(held_q - 1'b1);
        state_d = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        we      = 1'b1;
        held_d  = held_q - 1'b1;
        state_d = S_OUT;
      end
      S_SORT_LD: begin
        // Insertion sort: take entry idx as the key and walk it downward.
        jdx_d = idx_q;
        if (idx_q >= held_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SORT_X;
        end
      end
      S_SORT_X: begin
        x_d     = rdata;
        state_d = S_SORT_RD;
      end
      S_SORT_RD: begin
        raddr = AW'(jdx_q - 1'b1);
        if (jdx_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = x_q;
          idx_d   = idx_q + 1'b1;
          state_d = S_SORT_LD;
        end else begin
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = jdx_q[AW-1:0];
        if (cmp_res.after) begin
          wdata   = rdata;
          jdx_d   = jdx_q - 1'b1;
          state_d = S_SORT_RD;
        end else begin
          wdata   = x_q;
          idx_d   = idx_q + 1'b1;
          state_d = S_SORT_LD;
        end
      end
      S_READ_RD: begin
        raddr = AW'(pos_q);
        if (PW'(pos_q) >= PW'(cap_eff)) begin
          status_d = ST_RANGE;
          state_d  = S_OUT;
        end else begin
          state_d = S_READ_WAIT;
        end
      end
      S_READ_WAIT: begin
        rd_d    = 32'(rdata);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign status_o     = status_q;
  assign found_at_o   = found_q;
  assign read_value_o = rd_q;
  assign fill_count_o = 6'(held_q);

  `BVLE_ASSERT_SAME(a_held_bound, 1'b1, int'(held_q) <= int'(DEPTH), "held count above depth")
  `BVLE_ASSERT_SAME(a_one_side, in_ready_o, !out_valid_o, "ready while a result waits")
  `BVLE_ASSERT_NEXT(a_swap_dec, state_q == S_SWAP_WR, held_q == $past(held_q) - 1'b1,
                    "removal did not drop the count")

endmodule
